[hw/rtl/lbcs_pkg.sv]
// shared types and constants for the least busy channel selector
package lbcs_pkg;

    localparam int CHANNELS = 256;
    localparam int CH_W     = $clog2(CHANNELS);

    localparam int OP_W     = 2;
    localparam int CHAN_W   = 8;
    localparam int COUNT_W  = 8;
    localparam int RATE_W   = 8;
    localparam int USE_W    = 9;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_RATE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = 2'd1;

    localparam logic [RATE_W-1:0] SCAN_RATE_RESET = 8'd100;
    localparam logic [USE_W-1:0]  CHANNELS_IN_USE_RESET = 9'd256;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [RATE_W-1:0] scan_rate;
        logic [USE_W-1:0]  channels_in_use;
    } lbcs_cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } lbcs_state_t;

endpackage

[hw/rtl/lbcs_if.sv]
// channel interfaces: request, response and configuration write

interface lbcs_req_if;
    import lbcs_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CHAN_W-1:0] channel;
    logic              cca_busy;

    modport source (output valid, output operation, output channel, output cca_busy,
                    input ready);
    modport sink (input valid, input operation, input channel, input cca_busy,
                  output ready);
endinterface

interface lbcs_rsp_if;
    import lbcs_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  best_channel;
    logic [COUNT_W-1:0] best_count;
    logic               found;

    modport source (output valid, output best_channel, output best_count, output found,
                    input ready);
    modport sink (input valid, input best_channel, input best_count, input found,
                  output ready);
endinterface

interface lbcs_cfg_if;
    import lbcs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

[hw/rtl/lbcs_ram.sv]
// generic single-port synchronous ram with registered read
module lbcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/lbcs_ctrl.sv]
// sequencer: clearing pass, counter read-modify-write and pick scan over the ram
module lbcs_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lbcs_pkg::lbcs_cfg_t         cfg_regs,
    lbcs_req_if.sink                    req,
    lbcs_rsp_if.source                  rsp,
    output logic                        ram_we,
    output logic [lbcs_pkg::CH_W-1:0]   ram_addr,
    output logic [lbcs_pkg::COUNT_W-1:0] ram_wdata,
    input  logic [lbcs_pkg::COUNT_W-1:0] ram_rdata
);
    import lbcs_pkg::*;

    lbcs_state_t state_reg, state_next;

    logic [OP_W-1:0]    op_reg;
    logic [CHAN_W-1:0]  ch_reg;
    logic               busy_reg;
    logic [CH_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [USE_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               pend_reg, pend_next;
    logic [CH_W-1:0]    cmp_idx_reg;
    logic [COUNT_W-1:0] lowest_reg, lowest_next;
    logic [CH_W-1:0]    best_reg, best_next;
    logic               hit_reg, hit_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [CHAN_W-1:0]  rsp_chan_reg;
    logic [COUNT_W-1:0] rsp_count_reg;
    logic               rsp_found_reg;

    logic             req_fire;
    logic             ch_ok;
    logic [USE_W-1:0] scan_len;
    logic             issue;
    logic             zero_hit;
    logic             rsp_load;

    assign req_fire = req.valid && req.ready;
    assign ch_ok    = ({1'b0, ch_reg} < USE_W'(CHANNELS));
    assign scan_len = (cfg_regs.channels_in_use > USE_W'(CHANNELS))
                      ? USE_W'(CHANNELS) : cfg_regs.channels_in_use;
    assign issue    = (rd_cnt_reg < scan_len);
    assign zero_hit = pend_reg && (ram_rdata == '0);
    assign rsp_load = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CH_W'(CHANNELS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.operation)
                        OP_CLEAR:  state_next = ST_WRITE;
                        OP_SAMPLE: state_next = ST_READ;
                        OP_PICK:   state_next = ST_SCAN;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (zero_hit || !issue)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs toward the ram and the request channel
    always_comb
    begin
        req.ready = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = ch_reg[CH_W-1:0];
        ram_wdata = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_WRITE:
            begin
                if (op_reg == OP_CLEAR)
                begin
                    ram_we = ch_ok;
                end
                else
                begin
                    ram_we    = ch_ok && busy_reg && (ram_rdata != COUNT_MAX);
                    ram_wdata = ram_rdata + COUNT_W'(1);
                end
            end
            ST_SCAN:
            begin
                ram_addr = rd_cnt_reg[CH_W-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // scan and counter datapath
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = 1'b0;
        lowest_next    = lowest_reg;
        best_next      = best_reg;
        hit_next       = hit_reg;
        rsp_valid_next = rsp_valid_reg;

        if (state_reg == ST_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + CH_W'(1);
        end

        if (state_reg == ST_IDLE && req_fire)
        begin
            rd_cnt_next = '0;
            lowest_next = cfg_regs.scan_rate;
            best_next   = '0;
            hit_next    = 1'b0;
        end

        if (state_reg == ST_SCAN)
        begin
            pend_next = issue && !zero_hit;
            if (issue)
            begin
                rd_cnt_next = rd_cnt_reg + USE_W'(1);
            end
            // a zero count ends the scan at once
            if (zero_hit)
            begin
                lowest_next = '0;
                best_next   = cmp_idx_reg;
                hit_next    = 1'b1;
            end
            else if (pend_reg && (ram_rdata < lowest_reg))
            begin
                lowest_next = ram_rdata;
                best_next   = cmp_idx_reg;
                hit_next    = 1'b1;
            end
        end

        if (rsp.valid && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg   <= req.operation;
            ch_reg   <= req.channel;
            busy_reg <= req.cca_busy;
        end
        cmp_idx_reg <= rd_cnt_reg[CH_W-1:0];
        lowest_reg  <= lowest_next;
        best_reg    <= best_next;
        if (rsp_load)
        begin
            rsp_chan_reg  <= CHAN_W'(best_reg);
            rsp_count_reg <= lowest_reg;
            rsp_found_reg <= hit_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.best_channel = rsp_chan_reg;
    assign rsp.best_count   = rsp_count_reg;
    assign rsp.found        = rsp_found_reg;

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DONE) |-> !ram_we)
        else $error("counter memory written during a pick");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside pick completion");

    a_not_found_chan0: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_found_reg) |-> (rsp_chan_reg == '0))
        else $error("miss reported with nonzero channel");

    a_busy_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!req.ready && ram_we))
        else $error("request taken during clearing pass");

endmodule

[hw/rtl/least_busy_channel_selector_core.sv]
// Least busy channel selector: one 8-bit busy counter per channel held in a
// single-port ram. After reset the block zeroes all CHANNELS (256) counters
// of the ram and holds req.ready low meanwhile. A clear transaction steps
// through accept and write, a sample through accept, read and write back,
// and a pick scans up to min(channels_in_use, CHANNELS) counters, fewer
// when a zero count ends the scan early; the single ram port is read one
// counter per cycle during the scan. One item is in flight at a time. A pick
// result sits in an output register, so the next request is taken while it
// waits on rsp.ready; a pick that completes while the previous result still
// waits holds in its done state until rsp.ready frees the register.
// Configuration writes are always ready and should only be issued while idle.
module least_busy_channel_selector_core (
    input  logic    clk,
    input  logic    rst_n,
    lbcs_req_if.sink   req,
    lbcs_rsp_if.source rsp,
    lbcs_cfg_if.sink   cfg
);
    import lbcs_pkg::*;

    logic [RATE_W-1:0]  scan_rate_reg;
    logic [USE_W-1:0]   channels_in_use_reg;
    lbcs_cfg_t          cfg_regs;

    logic               ram_we;
    logic [CH_W-1:0]    ram_addr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [COUNT_W-1:0] ram_rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_rate_reg       <= SCAN_RATE_RESET;
            channels_in_use_reg <= CHANNELS_IN_USE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.addr == REG_SCAN_RATE)
            begin
                scan_rate_reg <= cfg.data[RATE_W-1:0];
            end
            else if (cfg.addr == REG_CHANNELS_IN_USE)
            begin
                channels_in_use_reg <= cfg.data[USE_W-1:0];
            end
        end
    end

    assign cfg_regs.scan_rate       = scan_rate_reg;
    assign cfg_regs.channels_in_use = channels_in_use_reg;

    lbcs_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (CHANNELS)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    lbcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

endmodule
